@@ design/ctm_pkg.sv @@
// ctm_pkg: shared constants, register codes and controller/datapath structs
// for the CA transition matrix power block. No dependencies.
package ctm_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int EXP_BITS_DEF  = 64;

    localparam int GRID_W     = 7;
    localparam int RULE_W     = 3;
    localparam int EXP_W      = 64;
    localparam int ROW_IDX_W  = 6;
    localparam int ROW_BITS_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [GRID_W-1:0] GRID_WIDTH_RST = 7'd64;
    localparam logic [RULE_W-1:0] RULE_BITS_RST  = 3'd5;
    localparam logic              WRAP_MODE_RST  = 1'b1;

    // neighbour tap positions in rule_bits
    localparam int RULE_LEFT  = 0;
    localparam int RULE_SELF  = 1;
    localparam int RULE_RIGHT = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH = 2'd0,
        CFG_RULE_BITS  = 2'd1,
        CFG_WRAP_MODE  = 2'd2
    } ctm_cfg_idx_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sqr_step;
        logic sqr_commit;
        logic emit_step;
    } ctm_cmd_t;

    typedef struct packed {
        logic exp_bit;
        logic exp_last;
        logic last_row;
    } ctm_sts_t;

endpackage

@@ design/ctm_in_if.sv @@
// ctm_in_if: input channel carrying one exponent word.
// Depends on ctm_pkg.
interface ctm_in_if import ctm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EXP_W-1:0] exponent;

    modport source (output valid, output exponent, input ready);
    modport sink   (input valid, input exponent, output ready);
endinterface

@@ design/ctm_out_if.sv @@
// ctm_out_if: output channel carrying one matrix row word.
// Depends on ctm_pkg.
interface ctm_out_if import ctm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last_row;

    modport source (output valid, output row_index, output row_bits, output last_row,
                    input ready);
    modport sink   (input valid, input row_index, input row_bits, input last_row,
                    output ready);
endinterface

@@ design/ctm_datapath.sv @@
// ctm_datapath: config registers, matrix row registers and GF(2) row product.
// Depends on ctm_pkg; driven by ctm_ctrl commands.
module ctm_datapath import ctm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int EXP_BITS  = EXP_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [EXP_W-1:0]      exponent,
    input  ctm_cmd_t              cmd,
    output ctm_sts_t              sts,
    output logic [ROW_IDX_W-1:0]  row_index,
    output logic [ROW_BITS_W-1:0] row_bits,
    output logic                  last_row
);

    logic [GRID_W-1:0]    grid_width_reg;
    logic [RULE_W-1:0]    rule_bits_reg;
    logic                 wrap_mode_reg;
    logic [GRID_W-1:0]    w_eff;

    // s: square (b operand, read whole), r: rotating copy of s (a operand when
    // squaring), a: accumulator, t: squaring results
    logic [MAX_WIDTH-1:0] s_reg [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_reg [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] a_reg [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] t_reg [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] base  [MAX_WIDTH];

    logic [EXP_BITS-1:0]  e_reg;
    logic [ROW_IDX_W-1:0] row_cnt_reg;

    logic [MAX_WIDTH-1:0] lsb;
    logic [MAX_WIDTH-1:0] wrap_top;
    logic [MAX_WIDTH-1:0] a_op;
    logic [MAX_WIDTH-1:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RST;
            rule_bits_reg  <= RULE_BITS_RST;
            wrap_mode_reg  <= WRAP_MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH: grid_width_reg <= cfg_data[GRID_W-1:0];
                CFG_RULE_BITS:  rule_bits_reg  <= cfg_data[RULE_W-1:0];
                CFG_WRAP_MODE:  wrap_mode_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = GRID_W'(1);
        else if (grid_width_reg > GRID_W'(MAX_WIDTH))
            w_eff = GRID_W'(MAX_WIDTH);
        else
            w_eff = grid_width_reg;
    end

    assign lsb      = MAX_WIDTH'(1);
    assign wrap_top = lsb << (w_eff - GRID_W'(1));

    // transition matrix; cyclic taps that coincide cancel
    always_comb
    begin
        for (int r = 0; r < MAX_WIDTH; r++)
        begin
            base[r] = '0;
            if (r < int'(w_eff))
            begin
                if (rule_bits_reg[RULE_SELF])
                    base[r] ^= lsb << r;
                if (rule_bits_reg[RULE_LEFT])
                begin
                    if (r > 0)
                        base[r] ^= lsb << (r - 1);
                    else if (wrap_mode_reg)
                        base[r] ^= wrap_top;
                end
                if (rule_bits_reg[RULE_RIGHT])
                begin
                    if (r + 1 < int'(w_eff))
                        base[r] ^= lsb << (r + 1);
                    else if (wrap_mode_reg)
                        base[r] ^= lsb;
                end
            end
        end
    end

    // one product row: XOR of the s rows selected by the head row's bits
    assign a_op = cmd.sqr_step ? r_reg[0] : a_reg[0];

    always_comb
    begin
        prod = '0;
        for (int k = 0; k < MAX_WIDTH; k++)
        begin
            if (a_op[k])
                prod ^= s_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int r = 0; r < MAX_WIDTH; r++)
            begin
                s_reg[r] <= base[r];
                r_reg[r] <= base[r];
                a_reg[r] <= (r < int'(w_eff)) ? (lsb << r) : '0;
            end
            e_reg <= exponent[EXP_BITS-1:0];
        end
        else if (cmd.mul_step || cmd.emit_step)
        begin
            for (int j = 0; j < MAX_WIDTH - 1; j++)
                a_reg[j] <= a_reg[j+1];
            a_reg[MAX_WIDTH-1] <= cmd.mul_step ? prod : a_reg[0];
        end
        else if (cmd.sqr_step)
        begin
            for (int j = 0; j < MAX_WIDTH - 1; j++)
            begin
                r_reg[j] <= r_reg[j+1];
                t_reg[j] <= t_reg[j+1];
            end
            r_reg[MAX_WIDTH-1] <= r_reg[0];
            t_reg[MAX_WIDTH-1] <= prod;
        end
        else if (cmd.sqr_commit)
        begin
            for (int r = 0; r < MAX_WIDTH; r++)
            begin
                s_reg[r] <= t_reg[r];
                r_reg[r] <= t_reg[r];
            end
            e_reg <= e_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_cnt_reg <= '0;
        else if (cmd.load)
            row_cnt_reg <= '0;
        else if (cmd.emit_step)
            row_cnt_reg <= row_cnt_reg + ROW_IDX_W'(1);
    end

    assign last_row     = (GRID_W'(row_cnt_reg) == (w_eff - GRID_W'(1)));
    assign row_index    = row_cnt_reg;
    assign row_bits     = ROW_BITS_W'(a_reg[0]);
    assign sts.exp_bit  = e_reg[0];
    assign sts.exp_last = ((e_reg >> 1) == '0);
    assign sts.last_row = last_row;

endmodule

@@ design/ctm_ctrl.sv @@
// ctm_ctrl: square-and-multiply sequencer and channel handshakes.
// Depends on ctm_pkg; commands ctm_datapath.
module ctm_ctrl import ctm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     exp_valid,
    output logic     exp_ready,
    output logic     row_valid,
    input  logic     row_ready,
    output ctm_cmd_t cmd,
    input  ctm_sts_t sts
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECIDE = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_POST   = 7'b0001000,
        ST_SQR    = 7'b0010000,
        ST_COMMIT = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] step_cnt_reg, step_cnt_next;
    logic          last_step;

    assign last_step = (step_cnt_reg == CW'(MAX_WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        exp_ready     = 1'b0;
        row_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                exp_ready = 1'b1;
                if (exp_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                step_cnt_next = '0;
                if (sts.exp_bit)
                    state_next = ST_MUL;
                else if (sts.exp_last)
                    state_next = ST_EMIT;
                else
                    state_next = ST_SQR;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (last_step)
                begin
                    step_cnt_next = '0;
                    state_next    = ST_POST;
                end
                else
                    step_cnt_next = step_cnt_reg + CW'(1);
            end
            ST_POST:
            begin
                state_next = sts.exp_last ? ST_EMIT : ST_SQR;
            end
            ST_SQR:
            begin
                cmd.sqr_step = 1'b1;
                if (last_step)
                begin
                    step_cnt_next = '0;
                    state_next    = ST_COMMIT;
                end
                else
                    step_cnt_next = step_cnt_reg + CW'(1);
            end
            ST_COMMIT:
            begin
                cmd.sqr_commit = 1'b1;
                state_next     = ST_DECIDE;
            end
            ST_EMIT:
            begin
                row_valid = 1'b1;
                if (row_ready)
                begin
                    cmd.emit_step = 1'b1;
                    if (sts.last_row)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ca_transition_matrix_power_core.sv @@
// ca_transition_matrix_power_core: top level; raises the CA transition matrix
// to an exponent over GF(2). Depends on ctm_pkg, ctm_in_if, ctm_out_if,
// ctm_ctrl and ctm_datapath.
//
//   channel  dir  payload                          handshake
//   exp_ch   in   exponent[63:0]                   valid/ready
//   row_ch   out  row_index[5:0] row_bits[63:0]    valid/ready
//                 last_row
//   cfg      in   cfg_index[1:0] cfg_data[6:0]     cfg_we
//
// One word in, w row words out. Per item: a load, then per exponent bit a
// decide step, a multiply pass over MAX_WIDTH rows if the bit is set, and a
// squaring pass over MAX_WIDTH rows unless it is the top set bit; then w rows.
// Each product row goes through the shared parity-tree row unit.
// Reset restores the register defaults; no clearing pass. A stalled row holds.
module ca_transition_matrix_power_core import ctm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int EXP_BITS  = EXP_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ctm_in_if.sink                exp_ch,
    ctm_out_if.source             row_ch
);

    ctm_cmd_t cmd;
    ctm_sts_t sts;

    ctm_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .exp_valid (exp_ch.valid),
        .exp_ready (exp_ch.ready),
        .row_valid (row_ch.valid),
        .row_ready (row_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ctm_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .EXP_BITS  (EXP_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .exponent  (exp_ch.exponent),
        .cmd       (cmd),
        .sts       (sts),
        .row_index (row_ch.row_index),
        .row_bits  (row_ch.row_bits),
        .last_row  (row_ch.last_row)
    );

endmodule

@@ design/ctm_checker.sv @@
// ctm_checker: port-level assertions for ca_transition_matrix_power_core,
// attached by bind. Depends on ctm_pkg.
module ctm_checker import ctm_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  exp_valid,
    input logic                  exp_ready,
    input logic                  row_valid,
    input logic                  row_ready,
    input logic [ROW_IDX_W-1:0]  row_index,
    input logic [ROW_BITS_W-1:0] row_bits,
    input logic                  last_row
);

    // stalled row word holds
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (row_valid && !row_ready) |=> (row_valid && $stable(row_bits) && $stable(row_index)))
        else $error("row word changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> !exp_ready)
        else $error("exponent taken while rows pending");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (row_valid && row_ready && !last_row) |=>
            (row_valid && (row_index == $past(row_index) + ROW_IDX_W'(1))))
        else $error("rows out of order");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (row_valid && row_ready && last_row) |=> (!row_valid && exp_ready))
        else $error("rows continue after last row");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_valid && exp_ready) |=> (!exp_ready && !row_valid))
        else $error("not busy after exponent taken");

endmodule

bind ca_transition_matrix_power_core ctm_checker u_ctm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .exp_valid (exp_ch.valid),
    .exp_ready (exp_ch.ready),
    .row_valid (row_ch.valid),
    .row_ready (row_ch.ready),
    .row_index (row_ch.row_index),
    .row_bits  (row_ch.row_bits),
    .last_row  (row_ch.last_row)
);
